@@ hdl/hft_pkg.sv @@
// Package: shared types and constants of the HTTP flow tracker.
`default_nettype none
package hft_pkg;
    localparam int TableDepth = 4096;
    localparam int SlotW      = $clog2(TableDepth);
    localparam int CntW       = SlotW + 1;

    localparam logic [2:0] EvIgnored  = 3'd0;
    localparam logic [2:0] EvOpened   = 3'd1;
    localparam logic [2:0] EvReopened = 3'd2;
    localparam logic [2:0] EvData     = 3'd3;
    localparam logic [2:0] EvFull     = 3'd4;
    localparam logic [2:0] EvTick     = 3'd5;

    localparam logic CfgServerPort = 1'b0;
    localparam logic CfgTimeout    = 1'b1;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] ack_base;
        logic [15:0] req_len;
        logic [31:0] total;
        logic        active;
        logic [7:0]  idle;
        logic        responding;
        logic        partial;
    } t_entry;

    typedef struct packed {
        logic        cmd;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [7:0]  tcp_flags;
        logic [15:0] payload_len;
        logic        payload_is_get;
        logic        status_is_206;
    } t_in;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [11:0] slot;
        logic [31:0] flow_key;
        logic [31:0] write_offset;
        logic [15:0] write_len;
        logic        first_response;
        logic        closed;
        logic [31:0] byte_count;
        logic        closed_partial;
        logic [12:0] active_count;
        logic [12:0] expired_count;
        logic [12:0] peak_open;
    } t_out;
endpackage
`default_nettype wire

@@ hdl/hft_if.sv @@
// Interface: valid/ready channel carrying one item.
`default_nettype none
interface hft_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/http_flow_tracker.sv @@
// Top level: HTTP flow tracker with a linearly probed entry table.
//
// Usage: items enter on in_ch (valid/ready), one result leaves per item on
// out_ch. cmd 0 is a packet: its key is hashed and the table probed from
// the home slot, each slot through a StRead and a StProbe state (registered
// memory read). cmd 1 is a tick: a sweep reads every slot and rewrites
// every occupied one, each slot through StSweepRd and StSweep.
// After reset a clearing pass writes every slot empty; in_ch.ready stays
// low meanwhile, config writes are still taken.
// One item at a time: ready is low from acceptance until the result has
// been taken, so a stalled receiver holds the block and the result.
// Configuration: i_cfg_we, i_cfg_index (0 server_port, 1 zero_io_timeout),
// i_cfg_data; the user must write these only while idle, the block does not enforce it.
`default_nettype none
module http_flow_tracker import hft_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    hft_if.sink              in_ch,
    hft_if.source            out_ch
);
    localparam logic [2:0] StClear = 3'd0, StIdle = 3'd1, StHash = 3'd2,
        StRead = 3'd3, StProbe = 3'd4, StSweepRd = 3'd5, StSweep = 3'd6,
        StOut = 3'd7;

    logic [2:0]       r_st, n_st;
    logic [15:0]      r_port;
    logic [7:0]       r_tmo;
    t_in              r_in;
    logic [31:0]      r_key;
    logic [SlotW-1:0] r_addr;
    logic [CntW-1:0]  r_cnt;
    logic [12:0]      r_open, r_peak, r_act, r_exp;
    logic [31:0]      r_ibytes;
    t_out             r_out;
    logic             r_we;
    logic [SlotW-1:0] r_waddr;
    t_entry           r_wdata;
    t_entry           w_rd;

    hft_mem u_mem (.i_clk(i_clk), .i_we(r_we), .i_waddr(r_waddr),
        .i_wdata(r_wdata), .i_raddr(r_addr), .o_rdata(w_rd));

    assign in_ch.ready = (r_st == StIdle);
    assign out_ch.valid = (r_st == StOut);
    assign out_ch.data = r_out;

    logic [31:0] w_key;
    logic        w_fwd;
    always_comb begin
        w_fwd = (r_in.dst_port == r_port);
        w_key = w_fwd
            ? r_in.src_ip*32'd33 + r_in.dst_ip*32'd37
              + {16'd0, r_in.src_port}*32'd23 + {16'd0, r_in.dst_port}*32'd3
            : r_in.dst_ip*32'd33 + r_in.src_ip*32'd37
              + {16'd0, r_in.dst_port}*32'd23 + {16'd0, r_in.src_port}*32'd3;
    end

    // packet decision on the read entry
    t_entry      e, w_new, w_open;
    logic [31:0] pos, tot, ib;
    logic        req_add;
    always_comb begin
        e = w_rd;
        pos = r_in.seq_num - e.ack_base;
        req_add = !e.responding;
        tot = e.total + (req_add ? {16'd0, e.req_len} : 32'd0)
            + {16'd0, r_in.payload_len};
        ib = r_ibytes + (req_add ? {16'd0, e.req_len} : 32'd0)
            + {16'd0, r_in.payload_len};
        w_new = e;
        w_new.responding = 1'b1;
        w_new.total = tot;
        w_new.idle = 8'd0;
        if ((req_add && e.req_len != 16'd0) || r_in.payload_len != 16'd0) begin
            w_new.active = 1'b1;
        end
        if (pos == 32'd0 && r_in.status_is_206) begin
            w_new.partial = 1'b1;
        end
        w_open = '0;
        w_open.key = r_key;
        w_open.ack_base = r_in.ack_num;
        w_open.req_len = r_in.payload_len;
    end

    logic [7:0] idl;
    t_entry     w_aged;
    always_comb begin
        idl = (w_rd.idle == 8'hFF) ? w_rd.idle : w_rd.idle + 8'd1;
        w_aged = w_rd;
        w_aged.active = 1'b0;
        w_aged.idle = idl;
    end

    logic [12:0] open_dec;
    assign open_dec = (r_open != 13'd0) ? r_open - 13'd1 : r_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StClear;
            r_port <= 16'd80;
            r_tmo <= 8'd3;
            r_cnt <= '0;
            r_open <= '0;
            r_peak <= '0;
            r_ibytes <= '0;
            r_we <= 1'b0;
        end else begin
            r_we <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == CfgServerPort) r_port <= i_cfg_data;
                else r_tmo <= i_cfg_data[7:0];
            end
            unique case (r_st)
                StClear: begin
                    r_we <= 1'b1;
                    r_waddr <= r_cnt[SlotW-1:0];
                    r_wdata <= '0;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CntW'(TableDepth - 1)) r_st <= StIdle;
                end
                StIdle: begin
                    if (in_ch.valid) begin
                        r_in <= in_ch.data;
                        r_out <= '0;
                        r_cnt <= '0;
                        r_act <= '0;
                        r_exp <= '0;
                        r_addr <= '0;
                        r_st <= in_ch.data.cmd ? StSweepRd : StHash;
                    end
                end
                StHash: begin
                    r_key <= w_key;
                    r_addr <= w_key[SlotW-1:0];
                    r_out.slot <= 12'(w_key[SlotW-1:0]);
                    r_out.flow_key <= w_key;
                    r_st <= (w_key == 32'd0) ? StOut : StRead;
                end
                StRead: r_st <= StProbe;
                StProbe: begin
                    if (w_rd.key == r_key || w_rd.key == 32'd0) begin
                        r_out.slot <= 12'(r_addr);
                        r_st <= StOut;
                        r_waddr <= r_addr;
                        if (r_in.payload_is_get) begin
                            r_we <= 1'b1;
                            r_wdata <= w_open;
                            if (w_rd.key != 32'd0) begin
                                r_out.event_kind <= EvReopened;
                                r_out.closed <= 1'b1;
                                r_out.byte_count <= w_rd.total;
                                r_out.closed_partial <= w_rd.partial;
                                // old entry closed, new one opened
                                r_open <= open_dec + 13'd1;
                                if (r_peak < open_dec + 13'd1) r_peak <= open_dec + 13'd1;
                            end else begin
                                r_out.event_kind <= EvOpened;
                                r_open <= r_open + 13'd1;
                                if (r_peak < r_open + 13'd1) r_peak <= r_open + 13'd1;
                            end
                        end else if (w_rd.key != 32'd0) begin
                            r_we <= 1'b1;
                            r_out.event_kind <= EvData;
                            r_out.first_response <= req_add;
                            r_out.write_offset <= pos + {16'd0, e.req_len};
                            r_out.write_len <= r_in.payload_len;
                            r_ibytes <= ib;
                            if ((r_in.tcp_flags & 8'd5) != 8'd0) begin
                                r_out.closed <= 1'b1;
                                r_out.byte_count <= tot;
                                r_out.closed_partial <= w_new.partial;
                                r_wdata <= '0;
                                r_open <= open_dec;
                            end else begin
                                r_wdata <= w_new;
                            end
                        end
                    end else if (r_cnt == CntW'(TableDepth - 1)) begin
                        r_out.event_kind <= EvFull;
                        r_st <= StOut;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                        r_addr <= r_addr + 1'b1;
                        r_st <= StRead;
                    end
                end
                StSweepRd: r_st <= StSweep;
                StSweep: begin
                    if (w_rd.key != 32'd0) begin
                        r_we <= 1'b1;
                        r_waddr <= r_addr;
                        if (w_rd.active) r_act <= r_act + 13'd1;
                        if (r_tmo != 8'd0 && idl >= r_tmo) begin
                            r_wdata <= '0;
                            r_exp <= r_exp + 13'd1;
                            r_open <= open_dec;
                        end else begin
                            r_wdata <= w_aged;
                        end
                    end
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == SlotW'(TableDepth - 1)) begin
                        r_out.event_kind <= EvTick;
                        r_out.closed <= (r_exp != 13'd0) || (w_rd.key != 32'd0
                            && r_tmo != 8'd0 && idl >= r_tmo);
                        r_out.byte_count <= r_ibytes;
                        r_out.active_count <= r_act + 13'(w_rd.key != 0 && w_rd.active);
                        r_out.expired_count <= r_exp + 13'(w_rd.key != 0
                            && r_tmo != 8'd0 && idl >= r_tmo);
                        r_out.peak_open <= r_peak;
                        r_ibytes <= '0;
                        r_peak <= '0;
                        r_st <= StOut;
                    end else begin
                        r_st <= StSweepRd;
                    end
                end
                StOut: if (out_ch.ready) r_st <= StIdle;
                default: r_st <= StIdle;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hdl/hft_mem.sv @@
// Entry table memory: one write port, one registered read port.
`default_nettype none
module hft_mem import hft_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [SlotW-1:0] i_waddr,
    input  wire t_entry           i_wdata,
    input  wire logic [SlotW-1:0] i_raddr,
    output t_entry                o_rdata
);
    t_entry r_mem [TableDepth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ test/tb_http_flow_tracker.sv @@
// Testbench: HTTP flow tracker checked against a behavioral flow table.
`default_nettype none
module tb_http_flow_tracker import hft_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 40000;

    class flow_scoreboard;
        logic [15:0] server_port;
        logic [7:0]  zero_io_timeout;
        t_entry      tbl[TableDepth];
        int unsigned open_cnt, peak_cnt;
        logic [31:0] interval_bytes;
        t_out        pending[$];
        int          errors;

        function void init();
            server_port = 16'd80;
            zero_io_timeout = 8'd3;
            foreach (tbl[s]) tbl[s] = '0;
            open_cnt = 0;
            peak_cnt = 0;
            interval_bytes = 0;
            errors = 0;
        endfunction

        function void set_reg(logic idx, logic [15:0] val);
            if (idx == CfgServerPort) server_port = val;
            else zero_io_timeout = val[7:0];
        endfunction

        function logic [31:0] flow_hash(t_in p);
            if (p.dst_port == server_port)
                return p.src_ip * 33 + p.dst_ip * 37 + p.src_port * 23 + p.dst_port * 3;
            return p.dst_ip * 33 + p.src_ip * 37 + p.dst_port * 23 + p.src_port * 3;
        endfunction

        function void drop_entry(int s);
            tbl[s] = '0;
            if (open_cnt > 0) open_cnt--;
        endfunction

        function void credit(int s, logic [31:0] n);
            tbl[s].total += n;
            interval_bytes += n;
            if (n != 0) tbl[s].active = 1'b1;
        endfunction

        // Note an accepted input and queue the result it should produce.
        function void note_input(t_in p);
            t_out r;
            logic [31:0] key, pos;
            int s, i, act, exp_n;
            bit found;
            r = '0;
            if (p.cmd) begin
                act = 0;
                exp_n = 0;
                for (s = 0; s < TableDepth; s++) begin
                    if (tbl[s].key == 0) continue;
                    if (tbl[s].active) act++;
                    tbl[s].active = 1'b0;
                    if (tbl[s].idle != 8'hFF) tbl[s].idle++;
                    if (zero_io_timeout != 0 && tbl[s].idle >= zero_io_timeout) begin
                        drop_entry(s);
                        exp_n++;
                    end
                end
                r.event_kind = EvTick;
                r.closed = exp_n > 0;
                r.byte_count = interval_bytes;
                r.active_count = 13'(act);
                r.expired_count = 13'(exp_n);
                r.peak_open = 13'(peak_cnt);
                interval_bytes = 0;
                peak_cnt = 0;
                pending.push_back(r);
                return;
            end
            key = flow_hash(p);
            s = int'(key % TableDepth);
            r.slot = 12'(s);
            r.flow_key = key;
            r.event_kind = EvIgnored;
            if (key == 0) begin
                pending.push_back(r);
                return;
            end
            found = 0;
            for (i = 0; i < TableDepth; i++) begin
                if (tbl[s].key == key || tbl[s].key == 0) begin
                    found = 1;
                    break;
                end
                s = (s + 1) % TableDepth;
            end
            if (!found) begin
                r.event_kind = EvFull;
                pending.push_back(r);
                return;
            end
            r.slot = 12'(s);
            if (p.payload_is_get) begin
                if (tbl[s].key != 0) begin
                    r.event_kind = EvReopened;
                    r.closed = 1'b1;
                    r.byte_count = tbl[s].total;
                    r.closed_partial = tbl[s].partial;
                    drop_entry(s);
                end else begin
                    r.event_kind = EvOpened;
                end
                tbl[s].key = key;
                tbl[s].ack_base = p.ack_num;
                tbl[s].req_len = p.payload_len;
                open_cnt++;
                if (open_cnt > peak_cnt) peak_cnt = open_cnt;
                pending.push_back(r);
                return;
            end
            if (tbl[s].key == 0) begin
                pending.push_back(r);
                return;
            end
            pos = p.seq_num - tbl[s].ack_base;
            r.event_kind = EvData;
            if (!tbl[s].responding) begin
                tbl[s].responding = 1'b1;
                r.first_response = 1'b1;
                credit(s, {16'd0, tbl[s].req_len});
            end
            if (pos == 0 && p.status_is_206) tbl[s].partial = 1'b1;
            r.write_offset = pos + {16'd0, tbl[s].req_len};
            r.write_len = p.payload_len;
            credit(s, {16'd0, p.payload_len});
            tbl[s].idle = 0;
            if (p.tcp_flags[0] || p.tcp_flags[2]) begin
                r.closed = 1'b1;
                r.byte_count = tbl[s].total;
                r.closed_partial = tbl[s].partial;
                drop_entry(s);
            end
            pending.push_back(r);
        endfunction

        function void report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
            errors++;
        endfunction

        function void check_result(t_out got);
            t_out w;
            if (pending.size() == 0) begin
                report("unexpected result kind", got.event_kind, 0);
                return;
            end
            w = pending.pop_front();
            if (got.event_kind != w.event_kind) report("event_kind", got.event_kind, w.event_kind);
            if (got.slot != w.slot) report("slot", got.slot, w.slot);
            if (got.flow_key != w.flow_key) report("flow_key", got.flow_key, w.flow_key);
            if (got.write_offset != w.write_offset)
                report("write_offset", got.write_offset, w.write_offset);
            if (got.write_len != w.write_len) report("write_len", got.write_len, w.write_len);
            if (got.first_response != w.first_response)
                report("first_response", got.first_response, w.first_response);
            if (got.closed != w.closed) report("closed", got.closed, w.closed);
            if (got.byte_count != w.byte_count) report("byte_count", got.byte_count, w.byte_count);
            if (got.closed_partial != w.closed_partial)
                report("closed_partial", got.closed_partial, w.closed_partial);
            if (got.active_count != w.active_count)
                report("active_count", got.active_count, w.active_count);
            if (got.expired_count != w.expired_count)
                report("expired_count", got.expired_count, w.expired_count);
            if (got.peak_open != w.peak_open) report("peak_open", got.peak_open, w.peak_open);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;

    hft_if #(.T(t_in))  in_ch();
    hft_if #(.T(t_out)) out_ch();

    http_flow_tracker dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    flow_scoreboard sb = new();
    int idle_cycles = 0;
    bit stall_enable = 1'b1;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // Result side: random stalls, checks every accepted result.
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : sink_proc
        int gap;
        @(posedge i_clk);
        forever begin
            gap = stall_enable ? $urandom_range(0, 13) : 0;
            out_ch.ready <= (gap == 0);
            if (gap != 0) begin
                repeat (gap) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    // Client/server addressing kept in a small pool so flows get revisited.
    logic [31:0] ip_pool[8];
    logic [15:0] port_pool[8];
    logic [31:0] ack_pool[8];

    // valid stays high into the next item when there is no gap
    task automatic send(t_in p);
        int gap;
        gap = stall_enable ? $urandom_range(0, 13) : 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= p;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(p);
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    function automatic t_in flow_pkt(int f, bit to_server);
        t_in p;
        p = '0;
        p.src_ip = to_server ? ip_pool[f] : 32'h0A00_0001;
        p.dst_ip = to_server ? 32'h0A00_0001 : ip_pool[f];
        p.src_port = to_server ? port_pool[f] : sb.server_port;
        p.dst_port = to_server ? sb.server_port : port_pool[f];
        return p;
    endfunction

    task automatic rand_item();
        t_in p;
        int f, r;
        f = $urandom_range(0, 7);
        r = $urandom_range(0, 99);
        if (r < 3) begin
            p = '0;
            p.cmd = 1'b1;
        end else if (r < 10) begin
            p = ($bits(t_in))'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            p.cmd = 1'b0;
        end else if (r < 25) begin
            p = flow_pkt(f, 1'b1);
            p.payload_is_get = 1'b1;
            p.payload_len = 16'($urandom_range(4, 600));
            p.ack_num = $urandom;
            p.tcp_flags = 8'($urandom_range(0, 255));
            ack_pool[f] = p.ack_num;
        end else begin
            p = flow_pkt(f, 1'($urandom_range(0, 1)));
            p.seq_num = ($urandom_range(0, 3) == 0) ? ack_pool[f]
                                                     : ack_pool[f] + $urandom_range(0, 5000);
            if ($urandom_range(0, 30) == 0) p.seq_num = $urandom;
            p.ack_num = $urandom;
            p.payload_len = ($urandom_range(0, 20) == 0) ? 16'hFFFF
                                                          : 16'($urandom_range(0, 1460));
            p.status_is_206 = 1'($urandom_range(0, 1));
            p.tcp_flags = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'h10;
        end
        send(p);
    endtask

    initial begin : main_proc
        t_in p;
        int n;
        sb.init();
        foreach (ip_pool[k]) begin
            ip_pool[k] = $urandom;
            port_pool[k] = 16'($urandom_range(1024, 65535));
            ack_pool[k] = $urandom;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: open, data, 206, reopen, close, ignored, zero key, extremes, ticks.
        p = flow_pkt(0, 1'b1); p.payload_is_get = 1'b1; p.payload_len = 16'd100;
        p.ack_num = ack_pool[0]; p.tcp_flags = 8'h05; send(p);
        p = flow_pkt(0, 1'b0); p.seq_num = ack_pool[0]; p.payload_len = 16'd500;
        p.status_is_206 = 1'b1; send(p);
        p = flow_pkt(0, 1'b0); p.seq_num = ack_pool[0] + 500; p.payload_len = 16'hFFFF; send(p);
        p = flow_pkt(0, 1'b1); p.payload_is_get = 1'b1; p.payload_len = 16'hFFFF;
        p.ack_num = 32'hFFFF_FFFF; ack_pool[0] = p.ack_num; send(p);
        p = flow_pkt(0, 1'b0); p.seq_num = 32'd0; p.tcp_flags = 8'h01; send(p);
        p = flow_pkt(1, 1'b1); p.payload_is_get = 1'b1; p.payload_len = 16'd4;
        p.ack_num = ack_pool[1]; send(p);
        p = flow_pkt(1, 1'b0); p.seq_num = ack_pool[1]; p.payload_len = 16'd0; send(p);
        p = flow_pkt(1, 1'b0); p.seq_num = ack_pool[1] + 9; p.payload_len = 16'd7;
        p.tcp_flags = 8'h04; send(p);
        p = flow_pkt(2, 1'b0); p.payload_len = 16'd10; send(p);
        p = '0; send(p);
        p = '1; p.cmd = 1'b0; send(p);
        p = '0; p.cmd = 1'b1; send(p);
        p = flow_pkt(3, 1'b1); p.payload_is_get = 1'b1; p.ack_num = ack_pool[3]; send(p);
        repeat (4) begin
            p = '0; p.cmd = 1'b1; send(p);
        end
        wait_drain();

        // Random phases across register settings, extremes included.
        for (n = 0; n < 6; n++) begin
            wait_drain();
            case (n)
                0: begin write_reg(CfgServerPort, 16'd0);     write_reg(CfgTimeout, 16'd0);   end
                1: begin write_reg(CfgServerPort, 16'hFFFF);  write_reg(CfgTimeout, 16'hFF);  end
                2: begin write_reg(CfgServerPort, 16'd8080);  write_reg(CfgTimeout, 16'd1);   end
                3: begin
                    write_reg(CfgServerPort, 16'($urandom));
                    write_reg(CfgTimeout, 16'($urandom));
                end
                4: begin write_reg(CfgServerPort, 16'd80);    write_reg(CfgTimeout, 16'd2);   end
                default: stall_enable = 1'b0;
            endcase
            repeat (200) rand_item();
            if (n == 2) wait_drain();
            stall_enable = (n != 4);
        end
        stall_enable = 1'b1;
        wait_drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
hdl/hft_pkg.sv
hdl/hft_if.sv
hdl/hft_mem.sv
hdl/http_flow_tracker.sv
test/tb_http_flow_tracker.sv
